// File: design/wst_pkg.sv
// Shared codes for the write slot tracker: actions and result status.
package wst_pkg;

  typedef enum logic {
    ACT_ACQUIRE = 1'b0,
    ACT_RELEASE = 1'b1
  } action_e;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_FREE  = 2'd1;
  localparam logic [1:0] STATUS_NOT_BUSY = 2'd2;

endpackage

// File: design/wst_cell.sv
// One slot of the tracker: its addresses and links, and one stage of the lookup chain.
module wst_cell #(
  parameter int NUM_SLOTS  = 16,
  parameter int ADDR_WIDTH = 32,
  parameter int IDX        = 0
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic [5*$clog2(NUM_SLOTS+1)+2*ADDR_WIDTH:0]   scan_i,
  output logic [5*$clog2(NUM_SLOTS+1)+2*ADDR_WIDTH:0]   scan_o,
  input  logic [7*$clog2(NUM_SLOTS+1)+2*ADDR_WIDTH+1:0] upd_i
);

  localparam int LINK_W = $clog2(NUM_SLOTS + 1);
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NUM_SLOTS);
  localparam logic [LINK_W-1:0] MY_IDX    = LINK_W'(IDX);
  localparam logic [LINK_W-1:0] RST_NEXT  = LINK_W'(IDX + 1);

  typedef struct packed {
    logic [LINK_W-1:0]     id;
    logic [LINK_W-1:0]     free_head;
    logic [LINK_W-1:0]     free_next;
    logic                  id_busy;
    logic [LINK_W-1:0]     id_prev;
    logic [LINK_W-1:0]     id_next;
    logic [ADDR_WIDTH-1:0] id_stop;
    logic [ADDR_WIDTH-1:0] nxt_start;
  } scan_t;

  typedef struct packed {
    logic                  en;
    logic                  own_acq;
    logic [LINK_W-1:0]     own_idx;
    logic [LINK_W-1:0]     own_next;
    logic [LINK_W-1:0]     own_prev;
    logic [ADDR_WIDTH-1:0] start;
    logic [ADDR_WIDTH-1:0] stop;
    logic [LINK_W-1:0]     nx_idx;
    logic [LINK_W-1:0]     nx_val;
    logic [LINK_W-1:0]     pv_idx;
    logic [LINK_W-1:0]     pv_val;
  } upd_t;

  scan_t scan_in, scan_d, scan_q;
  upd_t  upd;

  logic [ADDR_WIDTH-1:0] start_q, stop_q;
  logic                  busy_q;
  logic [LINK_W-1:0]     next_q, prev_q;

  assign scan_in = scan_i;
  assign upd     = upd_i;
  assign scan_o  = scan_q;

  // Fill in whatever this slot knows about the item in flight.
  always_comb begin
    scan_d = scan_in;
    if (scan_in.free_head == MY_IDX) begin
      scan_d.free_next = next_q;
    end
    if (scan_in.id == MY_IDX) begin
      scan_d.id_busy = busy_q;
      scan_d.id_prev = prev_q;
      scan_d.id_next = next_q;
      scan_d.id_stop = stop_q;
    end
    // The successor of the released slot is the busy slot pointing back at it.
    if (busy_q && (scan_in.id != NULL_LINK) && (prev_q == scan_in.id)) begin
      scan_d.nxt_start = start_q;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q <= scan_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      next_q <= RST_NEXT;
      prev_q <= NULL_LINK;
    end else if (upd.en) begin
      if (upd.own_idx == MY_IDX) begin
        busy_q <= upd.own_acq;
        next_q <= upd.own_next;
        prev_q <= upd.own_prev;
      end else begin
        if (upd.nx_idx == MY_IDX) begin
          next_q <= upd.nx_val;
        end
        if (upd.pv_idx == MY_IDX) begin
          prev_q <= upd.pv_val;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd.en && upd.own_acq && (upd.own_idx == MY_IDX)) begin
      start_q <= upd.start;
      stop_q  <= upd.stop;
    end
  end

endmodule

// File: design/write_slot_tracker.sv
// Write slot tracker top level: control, list pointers and the chain of slot cells.
// Flow: an accepted word is held while its lookup crosses the registered cell chain,
//   then it commits to the result register, which waits while an untaken result is held.
// The block takes no new word until the last one has committed.
// Reset: the free chain runs 0 to NUM_SLOTS-1 at once, all slots idle, marks invalid;
//   slot addresses are undefined until written and get no clearing pass.
module write_slot_tracker #(
  parameter int NUM_SLOTS  = 16,
  parameter int ADDR_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [31:0] start_addr_i,
  input  logic [31:0] stop_addr_i,
  input  logic [3:0]  slot_id_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [3:0]  granted_slot_o,
  output logic [31:0] position_o,
  output logic        position_valid_o,
  output logic [31:0] synced_o,
  output logic        synced_valid_o
);

  localparam int LINK_W  = $clog2(NUM_SLOTS + 1);
  localparam int CNT_W   = $clog2(NUM_SLOTS);
  localparam int SCAN_W  = 5 * LINK_W + 2 * ADDR_WIDTH + 1;
  localparam int UPD_W   = 7 * LINK_W + 2 * ADDR_WIDTH + 2;
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NUM_SLOTS);
  localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(NUM_SLOTS - 1);

  // Controller states.
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  typedef struct packed {
    logic [LINK_W-1:0]     id;
    logic [LINK_W-1:0]     free_head;
    logic [LINK_W-1:0]     free_next;
    logic                  id_busy;
    logic [LINK_W-1:0]     id_prev;
    logic [LINK_W-1:0]     id_next;
    logic [ADDR_WIDTH-1:0] id_stop;
    logic [ADDR_WIDTH-1:0] nxt_start;
  } scan_t;

  typedef struct packed {
    logic                  en;
    logic                  own_acq;
    logic [LINK_W-1:0]     own_idx;
    logic [LINK_W-1:0]     own_next;
    logic [LINK_W-1:0]     own_prev;
    logic [ADDR_WIDTH-1:0] start;
    logic [ADDR_WIDTH-1:0] stop;
    logic [LINK_W-1:0]     nx_idx;
    logic [LINK_W-1:0]     nx_val;
    logic [LINK_W-1:0]     pv_idx;
    logic [LINK_W-1:0]     pv_val;
  } upd_t;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q;

  // Held word.
  logic                  action_q;
  logic [ADDR_WIDTH-1:0] start_q, stop_q;
  logic [LINK_W-1:0]     id_q;

  // List pointers and marks.
  logic [LINK_W-1:0]     free_head_q, free_head_d;
  logic [LINK_W-1:0]     newest_q, newest_d;
  logic [ADDR_WIDTH-1:0] cpos_q, cpos_d;
  logic                  cval_q, cval_d;
  logic [ADDR_WIDTH-1:0] smark_q, smark_d;
  logic                  sval_q, sval_d;

  // Result register.
  logic        out_valid_q;
  logic [1:0]  status_q, status_d;
  logic [3:0]  granted_q, granted_d;
  logic [31:0] position_q;
  logic        position_valid_q;
  logic [31:0] synced_q;
  logic        synced_valid_q;

  logic        in_fire, commit_go;
  logic [31:0] id_wide;
  logic        id_ok;

  scan_t       scan_head, scan_res;
  upd_t        upd;
  logic [SCAN_W-1:0] chain [NUM_SLOTS+1];

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  // Commit once the result register is free or being drained this cycle.
  assign commit_go  = (state_q == ST_COMMIT) && (!out_valid_q || out_ready_i);

  // Slot numbers past the pool map to null, so no cell answers and the release fails.
  assign id_wide = 32'(slot_id_i);
  assign id_ok   = id_wide < 32'(NUM_SLOTS);

  // Launch the lookup: the held word and free head stay put for the whole walk.
  always_comb begin
    scan_head           = '0;
    scan_head.id        = id_q;
    scan_head.free_head = free_head_q;
    scan_head.free_next = NULL_LINK;
    scan_head.id_busy   = 1'b0;
    scan_head.id_prev   = NULL_LINK;
    scan_head.id_next   = NULL_LINK;
  end

  assign chain[0] = scan_head;
  assign scan_res = chain[NUM_SLOTS];

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    wst_cell #(
      .NUM_SLOTS  (NUM_SLOTS),
      .ADDR_WIDTH (ADDR_WIDTH),
      .IDX        (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .scan_i (chain[i]),
      .scan_o (chain[i+1]),
      .upd_i  (UPD_W'(upd))
    );
  end

  // Work out the list edits from what the walk collected.
  always_comb begin
    free_head_d  = free_head_q;
    newest_d     = newest_q;
    cpos_d       = cpos_q;
    cval_d       = cval_q;
    smark_d      = smark_q;
    sval_d       = sval_q;
    status_d     = wst_pkg::STATUS_OK;
    granted_d    = 4'd0;
    upd          = '0;
    upd.en       = commit_go;
    upd.own_idx  = NULL_LINK;
    upd.own_next = NULL_LINK;
    upd.own_prev = NULL_LINK;
    upd.start    = start_q;
    upd.stop     = stop_q;
    upd.nx_idx   = NULL_LINK;
    upd.nx_val   = NULL_LINK;
    upd.pv_idx   = NULL_LINK;
    upd.pv_val   = NULL_LINK;

    if (action_q == wst_pkg::ACT_ACQUIRE) begin
      if (free_head_q == NULL_LINK) begin
        status_d = wst_pkg::STATUS_NO_FREE;
      end else begin
        // Pop the free head and append it behind the newest slot.
        free_head_d  = scan_res.free_next;
        upd.own_idx  = free_head_q;
        upd.own_acq  = 1'b1;
        upd.own_next = NULL_LINK;
        upd.own_prev = newest_q;
        if (newest_q != NULL_LINK) begin
          upd.nx_idx = newest_q;
          upd.nx_val = free_head_q;
        end
        newest_d = free_head_q;
        if (!sval_q) begin
          smark_d = start_q;
          sval_d  = 1'b1;
        end
        granted_d = 4'(free_head_q);
      end
    end else begin
      if (!scan_res.id_busy) begin
        status_d = wst_pkg::STATUS_NOT_BUSY;
      end else begin
        // Unlink the slot and push it on the free list.
        upd.own_idx  = id_q;
        upd.own_acq  = 1'b0;
        upd.own_next = free_head_q;
        upd.own_prev = NULL_LINK;
        if (scan_res.id_prev == NULL_LINK) begin
          // Oldest write retired: advance the committed position.
          cpos_d   = (scan_res.id_next != NULL_LINK) ? scan_res.nxt_start
                                                     : scan_res.id_stop;
          cval_d   = 1'b1;
        end else begin
          upd.nx_idx = scan_res.id_prev;
          upd.nx_val = scan_res.id_next;
        end
        if (scan_res.id_next != NULL_LINK) begin
          upd.pv_idx = scan_res.id_next;
          upd.pv_val = scan_res.id_prev;
        end else begin
          newest_d = scan_res.id_prev;
        end
        free_head_d = id_q;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_fire) state_d = ST_SCAN;
      ST_SCAN:   if (cnt_q == CNT_LAST) state_d = ST_COMMIT;
      ST_COMMIT: if (commit_go) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_SCAN) begin
        cnt_q <= (cnt_q == CNT_LAST) ? '0 : cnt_q + CNT_W'(1);
      end
    end
  end

  // Hold the accepted word for the walk and the commit.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      action_q <= action_i;
      start_q  <= ADDR_WIDTH'(start_addr_i);
      stop_q   <= ADDR_WIDTH'(stop_addr_i);
      id_q     <= id_ok ? LINK_W'(slot_id_i) : NULL_LINK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q <= '0;
      newest_q    <= NULL_LINK;
      cpos_q      <= '0;
      cval_q      <= 1'b0;
      smark_q     <= '0;
      sval_q      <= 1'b0;
    end else if (commit_go) begin
      free_head_q <= free_head_d;
      newest_q    <= newest_d;
      cpos_q      <= cpos_d;
      cval_q      <= cval_d;
      smark_q     <= smark_d;
      sval_q      <= sval_d;
    end
  end

  // Result register: load on commit, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit_go) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit_go) begin
      status_q         <= status_d;
      granted_q        <= granted_d;
      position_q       <= cval_d ? 32'(cpos_d) : 32'd0;
      position_valid_q <= cval_d;
      synced_q         <= sval_d ? 32'(smark_d) : 32'd0;
      synced_valid_q   <= sval_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign granted_slot_o   = granted_q;
  assign position_o       = position_q;
  assign position_valid_o = position_valid_q;
  assign synced_o         = synced_q;
  assign synced_valid_o   = synced_valid_q;

endmodule

// File: test/write_slot_tracker_tb.sv
// Self-checking testbench for the write slot tracker: directed and random acquire/release words.
module write_slot_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 16;
  localparam logic [4:0] NIL_LINK = 5'(SLOTS);
  // The block walks its cell chain for every word before it takes the next one.
  // The run limit allows for that, plus the worst gaps and stalls, many times over.
  localparam int DRAIN_CYCLES = SLOTS + 8;
  localparam int CYCLE_LIMIT = 400_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        action_i = 1'b0;
  logic [31:0] start_addr_i = '0;
  logic [31:0] stop_addr_i = '0;
  logic [3:0]  slot_id_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [3:0]  granted_slot_o;
  logic [31:0] position_o;
  logic        position_valid_o;
  logic [31:0] synced_o;
  logic        synced_valid_o;

  // One result word as the block should report it.
  typedef struct {
    logic [1:0]  status;
    logic [3:0]  granted;
    logic [31:0] position;
    logic        position_valid;
    logic [31:0] synced;
    logic        synced_valid;
  } tracker_result_t;

  tracker_result_t pending_results[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Shadow of the slot pool: addresses, busy flags and the two linked lists.
  logic [31:0] slot_start[SLOTS];
  logic [31:0] slot_stop[SLOTS];
  logic        slot_busy[SLOTS];
  logic [4:0]  next_link[SLOTS];
  logic [4:0]  prev_link[SLOTS];
  logic [4:0]  free_head;
  logic [4:0]  oldest_slot;
  logic [4:0]  newest_slot;
  logic [31:0] committed_pos;
  logic        committed_valid;
  logic [31:0] synced_mark;
  logic        synced_valid;
  int          busy_count;

  write_slot_tracker #(
    .NUM_SLOTS (SLOTS),
    .ADDR_WIDTH(32)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .start_addr_i    (start_addr_i),
    .stop_addr_i     (stop_addr_i),
    .slot_id_i       (slot_id_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .granted_slot_o  (granted_slot_o),
    .position_o      (position_o),
    .position_valid_o(position_valid_o),
    .synced_o        (synced_o),
    .synced_valid_o  (synced_valid_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Guard against a hang: a lost result or a stuck handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Stall the result channel at random, at the rate of the current phase.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Put the shadow pool into its post-reset state: free chain 0..15, nothing in use.
  task automatic reset_tracker();
    for (int i = 0; i < SLOTS; i++) begin
      slot_start[i] = '0;
      slot_stop[i]  = '0;
      slot_busy[i]  = 1'b0;
      next_link[i]  = 5'(i + 1);
      prev_link[i]  = NIL_LINK;
    end
    free_head       = 5'd0;
    oldest_slot     = NIL_LINK;
    newest_slot     = NIL_LINK;
    committed_pos   = '0;
    committed_valid = 1'b0;
    synced_mark     = '0;
    synced_valid    = 1'b0;
    busy_count      = 0;
  endtask

  // Apply one accepted word to the shadow pool and return the result it must give.
  function automatic tracker_result_t track_word(wst_pkg::action_e act, logic [31:0] start_a,
                                                 logic [31:0] stop_a, logic [3:0] id);
    tracker_result_t res;
    logic [4:0] s;
    logic [4:0] p;
    logic [4:0] n;
    res.status  = wst_pkg::STATUS_OK;
    res.granted = '0;
    if (act == wst_pkg::ACT_ACQUIRE) begin
      s = free_head;
      if (s == NIL_LINK) begin
        // Pool exhausted: flag it and leave every register alone.
        res.status = wst_pkg::STATUS_NO_FREE;
      end else begin
        // Pop the free head and append it behind the newest slot.
        free_head = next_link[s[3:0]];
        slot_start[s[3:0]] = start_a;
        slot_stop[s[3:0]]  = stop_a;
        slot_busy[s[3:0]]  = 1'b1;
        next_link[s[3:0]]  = NIL_LINK;
        prev_link[s[3:0]]  = newest_slot;
        if (newest_slot != NIL_LINK) begin
          next_link[newest_slot[3:0]] = s;
        end else begin
          oldest_slot = s;
        end
        newest_slot = s;
        if (!synced_valid) begin
          synced_mark  = start_a;
          synced_valid = 1'b1;
        end
        busy_count++;
        res.granted = s[3:0];
      end
    end else if (!slot_busy[id]) begin
      res.status = wst_pkg::STATUS_NOT_BUSY;
    end else begin
      s = {1'b0, id};
      p = prev_link[id];
      n = next_link[id];
      if (p == NIL_LINK) begin
        // Oldest write retired: advance the committed position to the next
        // oldest start, or to this write's end when the list runs empty.
        oldest_slot     = n;
        committed_pos   = (n != NIL_LINK) ? slot_start[n[3:0]] : slot_stop[id];
        committed_valid = 1'b1;
      end else begin
        next_link[p[3:0]] = n;
      end
      if (n != NIL_LINK) begin
        prev_link[n[3:0]] = p;
      end else begin
        newest_slot = p;
      end
      slot_busy[id] = 1'b0;
      prev_link[id] = NIL_LINK;
      next_link[id] = free_head;
      free_head     = s;
      busy_count--;
    end
    res.position       = committed_valid ? committed_pos : '0;
    res.position_valid = committed_valid;
    res.synced         = synced_valid ? synced_mark : '0;
    res.synced_valid   = synced_valid;
    return res;
  endfunction

  // Offer one word, hold it until accepted, then record what it must produce.
  // Valid is left high; the next word or the drain decides when it drops.
  task automatic send_word(wst_pkg::action_e act, logic [31:0] start_a, logic [31:0] stop_a,
                           logic [3:0] id);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    start_addr_i <= start_a;
    stop_addr_i  <= stop_a;
    slot_id_i    <= id;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    pending_results.push_back(track_word(act, start_a, stop_a, id));
  endtask

  // Drop valid and hold until every expected result has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic check_field(string name, logic [31:0] expected, logic [31:0] actual);
    if (expected !== actual) begin
      $error("%s mismatch: expected 0x%08h, got 0x%08h", name, expected, actual);
      mismatch_count++;
    end
  endtask

  // Compare each accepted result word against the oldest expectation.
  always @(posedge clk_i) begin
    tracker_result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result word with no expectation waiting");
        mismatch_count++;
      end else begin
        exp_res = pending_results.pop_front();
        check_field("status", 32'(exp_res.status), 32'(status_o));
        check_field("granted_slot", 32'(exp_res.granted), 32'(granted_slot_o));
        check_field("position", exp_res.position, position_o);
        check_field("position_valid", 32'(exp_res.position_valid), 32'(position_valid_o));
        check_field("synced", exp_res.synced, synced_o);
        check_field("synced_valid", 32'(exp_res.synced_valid), 32'(synced_valid_o));
      end
    end
  end

  // Straight after reset nothing is in use, so any release is refused.
  task automatic test_idle_release();
    send_word(wst_pkg::ACT_RELEASE, 32'h0, 32'h0, 4'd0);
    send_word(wst_pkg::ACT_RELEASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
  endtask

  // One write in and out: latches the synced mark, then commits its end
  // address because the list runs empty.
  task automatic test_single_write();
    send_word(wst_pkg::ACT_ACQUIRE, 32'h0000_0000, 32'hFFFF_FFFF, 4'd9);
    send_word(wst_pkg::ACT_RELEASE, 32'h1234_5678, 32'h8765_4321, 4'd0);
  endtask

  // Take every slot, then ask for one more to hit the exhausted pool.
  task automatic test_fill_pool();
    logic [31:0] base;
    for (int i = 0; i < SLOTS; i++) begin
      base = {4'(i), 28'h0AB_CDE0};
      send_word(wst_pkg::ACT_ACQUIRE, base, ~base, 4'(15 - i));
    end
    send_word(wst_pkg::ACT_ACQUIRE, 32'hFFFF_FFFF, 32'h0, 4'd3);
  endtask

  // Unlink from the middle (position holds), the oldest (position moves to
  // the next start) and the newest (tail pointer steps back).
  task automatic test_release_order();
    send_word(wst_pkg::ACT_RELEASE, '0, '0, 4'd7);
    send_word(wst_pkg::ACT_RELEASE, '0, '0, 4'd0);
    send_word(wst_pkg::ACT_RELEASE, '0, '0, 4'd15);
  endtask

  function automatic logic [31:0] random_addr();
    case ($urandom_range(15))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Mostly legal traffic whose occupancy drifts between nearly empty and
  // full, with a sprinkling of idle releases and acquires on a full pool.
  task automatic run_random_words(int count, int idle_pct, int stall_pct);
    int bias;
    int pick;
    int k;
    bit take;
    logic [3:0] id;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    bias = 50;
    for (k = 0; k < count; k++) begin
      if (k % 32 == 0) begin
        case ($urandom_range(2))
          0:       bias = 15;
          1:       bias = 50;
          default: bias = 85;
        endcase
      end
      if (busy_count == 0) begin
        take = ($urandom_range(99) < 92);
      end else if (busy_count == SLOTS) begin
        take = ($urandom_range(99) < 8);
      end else begin
        take = ($urandom_range(99) < bias);
      end
      if (take) begin
        send_word(wst_pkg::ACT_ACQUIRE, random_addr(), random_addr(),
                  4'($urandom_range(15)));
      end else begin
        pick = $urandom_range(99);
        if (busy_count == 0 || pick < 8) begin
          id = 4'($urandom_range(15));
        end else if (pick < 45) begin
          id = oldest_slot[3:0];
        end else begin
          do begin
            id = 4'($urandom_range(15));
          end while (!slot_busy[id]);
        end
        send_word(wst_pkg::ACT_RELEASE, $urandom, $urandom, id);
      end
    end
  endtask

  task automatic test_random_traffic();
    run_random_words(482, 0, 0);
    run_random_words(482, 59, 0);
    run_random_words(482, 0, 59);
    run_random_words(482, 11, 11);
  endtask

  initial begin
    reset_tracker();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_release();
    test_single_write();
    test_fill_pool();
    test_release_order();
    test_random_traffic();

    drain_results();
    // Give a stray extra result time to show up before judging.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
